### rtl/core/sseds_pkg.sv
package sseds_pkg;

	localparam int STEP_W   = 5;
	localparam int ACC_W    = 58;
	localparam int STATE_W  = 48;
	localparam int SAMPLE_W = 32;
	localparam int GAIN_W   = 32;
	localparam int DELAY_W  = 14;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [STEP_W-1:0]  STEP_IDLE = '0;
	localparam logic [DELAY_W-1:0] COUNT_MAX = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_STATE_GAIN_11 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STATE_GAIN_12 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STATE_GAIN_21 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STATE_GAIN_22 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN_1  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN_2  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WEIGHTS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEPS   = 3'd7;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_WAIT_IN,
		SEQ_WAIT_OUT
	} seq_cond_t;

	typedef enum logic [2:0] {
		A_G11, A_G12, A_G21, A_G22, A_H1, A_H2, A_C1, A_C2
	} a_sel_t;

	typedef enum logic [2:0] {
		B_LO1, B_HI1, B_LO2, B_HI2, B_U
	} b_sel_t;

	typedef enum logic [1:0] {
		BASE_ACC, BASE_X1, BASE_X2, BASE_ZERO
	} base_t;

	typedef enum logic [1:0] {
		TERM_NONE, TERM_SH0, TERM_SH16, TERM_SH24
	} term_t;

	typedef enum logic [2:0] {
		ACT_NONE, ACT_ACCEPT, ACT_SAVE1, ACT_COMMIT, ACT_WRITE, ACT_READ, ACT_PUBLISH
	} act_t;

	typedef struct packed {
		seq_cond_t         cond;
		logic              jump;
		logic [STEP_W-1:0] target;
		a_sel_t            a_sel;
		b_sel_t            b_sel;
		base_t             base;
		term_t             term;
		act_t              act;
	} uword_t;

	typedef struct packed {
		uword_t w;
		logic   fire;
	} ctrl_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] g11;
		logic signed [GAIN_W-1:0] g12;
		logic signed [GAIN_W-1:0] g21;
		logic signed [GAIN_W-1:0] g22;
		logic signed [GAIN_W-1:0] h1;
		logic signed [GAIN_W-1:0] h2;
		logic signed [GAIN_W-1:0] c1;
		logic signed [GAIN_W-1:0] c2;
		logic [DELAY_W-1:0]       delay;
	} cfg_t;

	// Microprogram. The term field of a step consumes the product issued
	// by the step before it.
	function automatic uword_t ucode(input logic [STEP_W-1:0] s);
		uword_t w;
		w = '{cond: SEQ_NEXT, jump: 1'b0, target: STEP_IDLE, a_sel: A_G11,
			b_sel: B_LO1, base: BASE_ACC, term: TERM_NONE, act: ACT_NONE};
		unique case (s)
			5'd0: begin
				w.cond = SEQ_WAIT_IN;
				w.act  = ACT_ACCEPT;
			end
			5'd1: begin
				w.a_sel = A_G11; w.b_sel = B_LO1;
			end
			5'd2: begin
				w.a_sel = A_G11; w.b_sel = B_HI1; w.base = BASE_X1; w.term = TERM_SH24;
			end
			5'd3: begin
				w.a_sel = A_G12; w.b_sel = B_LO2; w.term = TERM_SH0;
			end
			5'd4: begin
				w.a_sel = A_G12; w.b_sel = B_HI2; w.term = TERM_SH24;
			end
			5'd5: begin
				w.a_sel = A_H1; w.b_sel = B_U; w.term = TERM_SH0;
			end
			5'd6: begin
				w.a_sel = A_G21; w.b_sel = B_LO1; w.term = TERM_SH16;
			end
			5'd7: begin
				w.a_sel = A_G21; w.b_sel = B_HI1; w.base = BASE_X2; w.term = TERM_SH24;
				w.act = ACT_SAVE1;
			end
			5'd8: begin
				w.a_sel = A_G22; w.b_sel = B_LO2; w.term = TERM_SH0;
			end
			5'd9: begin
				w.a_sel = A_G22; w.b_sel = B_HI2; w.term = TERM_SH24;
			end
			5'd10: begin
				w.a_sel = A_H2; w.b_sel = B_U; w.term = TERM_SH0;
			end
			5'd11: begin
				w.term = TERM_SH16;
			end
			5'd12: begin
				w.act = ACT_COMMIT;
			end
			5'd13: begin
				w.a_sel = A_C1; w.b_sel = B_LO1;
			end
			5'd14: begin
				w.a_sel = A_C1; w.b_sel = B_HI1; w.base = BASE_ZERO; w.term = TERM_SH24;
			end
			5'd15: begin
				w.a_sel = A_C2; w.b_sel = B_LO2; w.term = TERM_SH0;
			end
			5'd16: begin
				w.a_sel = A_C2; w.b_sel = B_HI2; w.term = TERM_SH24;
			end
			5'd17: begin
				w.term = TERM_SH0;
			end
			5'd18: begin
				w.act = ACT_WRITE;
			end
			5'd19: begin
				w.act = ACT_READ;
			end
			5'd20: begin
				w.cond   = SEQ_WAIT_OUT;
				w.jump   = 1'b1;
				w.target = STEP_IDLE;
				w.act    = ACT_PUBLISH;
			end
			default: begin
				w.jump   = 1'b1;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	function automatic logic fits48(input logic [ACC_W-1:0] v);
		return v[ACC_W-1:STATE_W-1] == {(ACC_W-STATE_W+1){v[ACC_W-1]}};
	endfunction

	function automatic logic [STATE_W-1:0] clip48(input logic [ACC_W-1:0] v);
		if (fits48(v))
			return v[STATE_W-1:0];
		return v[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
	endfunction

	function automatic logic fits32(input logic [ACC_W-1:0] v);
		return v[ACC_W-1:SAMPLE_W-1] == {(ACC_W-SAMPLE_W+1){v[ACC_W-1]}};
	endfunction

	function automatic logic [SAMPLE_W-1:0] clip32(input logic [ACC_W-1:0] v);
		if (fits32(v))
			return v[SAMPLE_W-1:0];
		return v[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
	endfunction

endpackage

### rtl/core/sseds_in_if.sv
interface sseds_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [sseds_pkg::SAMPLE_W-1:0] sample_in;
	logic                              restart;

	modport source(output valid, output sample_in, output restart, input ready);
	modport sink(input valid, input sample_in, input restart, output ready);
endinterface

### rtl/core/sseds_out_if.sv
interface sseds_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [sseds_pkg::SAMPLE_W-1:0] sample_out;
	logic                              saturated;

	modport source(output valid, output sample_out, output saturated, input ready);
	modport sink(input valid, input sample_out, input saturated, output ready);
endinterface

### rtl/core/sseds_seq.sv
module sseds_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_free,
	output logic                 in_ready,
	output sseds_pkg::ctrl_t     ctrl
);

	logic [sseds_pkg::STEP_W-1:0] step_q;
	sseds_pkg::uword_t            word;
	logic                         fire;

	always_comb begin
		word = sseds_pkg::ucode(step_q);
		unique case (word.cond)
			sseds_pkg::SEQ_NEXT:     fire = 1'b1;
			sseds_pkg::SEQ_WAIT_IN:  fire = in_valid;
			sseds_pkg::SEQ_WAIT_OUT: fire = out_free;
			default:                 fire = 1'b0;
		endcase
	end

	assign in_ready = (word.cond == sseds_pkg::SEQ_WAIT_IN);
	assign ctrl     = '{w: word, fire: fire};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= sseds_pkg::STEP_IDLE;
		end else if (fire) begin
			if (word.jump)
				step_q <= word.target;
			else
				step_q <= step_q + 1'b1;
		end
	end

endmodule

### rtl/core/sseds_dp.sv
module sseds_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sseds_pkg::ctrl_t                      ctrl,
	input  sseds_pkg::cfg_t                       cfg,
	input  logic signed [sseds_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                  restart,
	output logic signed [sseds_pkg::SAMPLE_W-1:0] y,
	output logic                                  sat
);

	localparam int AW = sseds_pkg::ACC_W;
	localparam int SW = sseds_pkg::STATE_W;

	logic signed [31:0]   u_q;
	logic [SW-1:0]        x1_q, x2_q, tmp_q;
	logic signed [AW-1:0] acc_q, acc_d, base_v, term_v;
	logic signed [63:0]   prod_q, sh16, sh24;
	logic signed [31:0]   a_op, b_op;
	logic [AW-1:0]        y_wide;
	logic                 sat_q;

	always_comb begin
		case (ctrl.w.a_sel)
			sseds_pkg::A_G11: a_op = cfg.g11;
			sseds_pkg::A_G12: a_op = cfg.g12;
			sseds_pkg::A_G21: a_op = cfg.g21;
			sseds_pkg::A_G22: a_op = cfg.g22;
			sseds_pkg::A_H1:  a_op = cfg.h1;
			sseds_pkg::A_H2:  a_op = cfg.h2;
			sseds_pkg::A_C1:  a_op = cfg.c1;
			sseds_pkg::A_C2:  a_op = cfg.c2;
			default:          a_op = '0;
		endcase
		// The state enters the multiplier as a signed upper half and an
		// unsigned lower half of 24 bits each.
		case (ctrl.w.b_sel)
			sseds_pkg::B_LO1: b_op = {8'd0, x1_q[23:0]};
			sseds_pkg::B_HI1: b_op = {{8{x1_q[SW-1]}}, x1_q[SW-1:24]};
			sseds_pkg::B_LO2: b_op = {8'd0, x2_q[23:0]};
			sseds_pkg::B_HI2: b_op = {{8{x2_q[SW-1]}}, x2_q[SW-1:24]};
			sseds_pkg::B_U:   b_op = u_q;
			default:          b_op = '0;
		endcase
	end

	always_comb begin
		sh16 = prod_q >>> 16;
		sh24 = prod_q >>> 24;
		case (ctrl.w.term)
			sseds_pkg::TERM_SH0:  term_v = prod_q[AW-1:0];
			sseds_pkg::TERM_SH16: term_v = sh16[AW-1:0];
			sseds_pkg::TERM_SH24: term_v = sh24[AW-1:0];
			default:              term_v = '0;
		endcase
		case (ctrl.w.base)
			sseds_pkg::BASE_X1:   base_v = {{(AW-SW){x1_q[SW-1]}}, x1_q};
			sseds_pkg::BASE_X2:   base_v = {{(AW-SW){x2_q[SW-1]}}, x2_q};
			sseds_pkg::BASE_ZERO: base_v = '0;
			default:              base_v = acc_q;
		endcase
		acc_d  = base_v + term_v;
		y_wide = acc_q >>> 8;
	end

	assign y   = sseds_pkg::clip32(y_wide);
	assign sat = sat_q;

	always_ff @(posedge clk) begin
		prod_q <= a_op * b_op;
		acc_q  <= acc_d;
		if (ctrl.fire && ctrl.w.act == sseds_pkg::ACT_ACCEPT)
			u_q <= sample_in;
		if (ctrl.fire && ctrl.w.act == sseds_pkg::ACT_SAVE1)
			tmp_q <= sseds_pkg::clip48(acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q  <= '0;
			x2_q  <= '0;
			sat_q <= 1'b0;
		end else if (ctrl.fire) begin
			case (ctrl.w.act)
				sseds_pkg::ACT_ACCEPT: begin
					sat_q <= 1'b0;
					if (restart) begin
						x1_q <= '0;
						x2_q <= '0;
					end
				end
				sseds_pkg::ACT_SAVE1: begin
					sat_q <= sat_q | !sseds_pkg::fits48(acc_q);
				end
				sseds_pkg::ACT_COMMIT: begin
					x1_q  <= tmp_q;
					x2_q  <= sseds_pkg::clip48(acc_q);
					sat_q <= sat_q | !sseds_pkg::fits48(acc_q);
				end
				sseds_pkg::ACT_WRITE: begin
					sat_q <= sat_q | !sseds_pkg::fits32(y_wide);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/core/sseds_dly.sv
module sseds_dly #(
	parameter int DEPTH = 16384
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sseds_pkg::ctrl_t                      ctrl,
	input  logic [sseds_pkg::DELAY_W-1:0]         delay_steps,
	input  logic                                  restart,
	input  logic signed [sseds_pkg::SAMPLE_W-1:0] y,
	output logic signed [sseds_pkg::SAMPLE_W-1:0] delayed
);

	localparam int AW = $clog2(DEPTH);
	localparam int DW = sseds_pkg::DELAY_W;
	localparam int XW = ((AW > DW) ? AW : DW) + 1;

	logic [sseds_pkg::SAMPLE_W-1:0] mem [DEPTH];
	logic [sseds_pkg::SAMPLE_W-1:0] rd_data_q;
	logic [AW-1:0]                  wi_q;
	logic [DW-1:0]                  cnt_q;
	logic [DW-1:0]                  eff_delay;
	logic [XW-1:0]                  wi_x, d_x, rd_x, wi_inc;
	logic [AW-1:0]                  rd_addr;

	always_comb begin
		// Dead times beyond the line act as the longest one it holds.
		if ({18'd0, delay_steps} > 32'(DEPTH - 1))
			eff_delay = DW'(DEPTH - 1);
		else
			eff_delay = delay_steps;
		wi_x   = XW'(wi_q);
		d_x    = XW'(eff_delay);
		rd_x   = (wi_x >= d_x) ? (wi_x - d_x) : (wi_x + XW'(DEPTH) - d_x);
		rd_addr = rd_x[AW-1:0];
		wi_inc = wi_x + 1'b1;
	end

	assign delayed = (cnt_q >= eff_delay) ? rd_data_q : '0;

	always_ff @(posedge clk) begin
		if (ctrl.fire && ctrl.w.act == sseds_pkg::ACT_WRITE)
			mem[wi_q] <= y;
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire && ctrl.w.act == sseds_pkg::ACT_READ)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q  <= '0;
			cnt_q <= '0;
		end else if (ctrl.fire) begin
			if (ctrl.w.act == sseds_pkg::ACT_ACCEPT && restart)
				cnt_q <= '0;
			if (ctrl.w.act == sseds_pkg::ACT_PUBLISH) begin
				wi_q <= (wi_inc == XW'(DEPTH)) ? '0 : wi_inc[AW-1:0];
				if (cnt_q != sseds_pkg::COUNT_MAX)
					cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

### rtl/core/state_space_euler_step_with_delay.sv
// Second-order state-space simulator with output dead time.
// Words arrive on the feed channel (sample_in, restart) and leave on the
// result channel (sample_out, saturated), both valid/ready. Each accepted word
// advances the state by one forward Euler step and yields exactly one result.
// Gains and the dead time are loaded through cfg_we/cfg_index/cfg_data; the
// user must load them only while the block is idle, which the block itself
// does not enforce. A write takes effect at the clock edge that carries it.
// A word is accepted only while the sequencer sits at its idle step; its result
// is loaded into the output register at the publish step, and no new word is
// taken until that result is published. The microprogram runs 14 multiplies on
// the single shared 32x32 multiplier, two accumulator settle steps and the delay
// line's write and registered read, all in order on one datapath.
// A result waits in the output register while the receiver stalls; the next
// word is still accepted and computed, and the sequencer holds at its last step
// until the output register is free. Asynchronous reset clears the state, the
// step counter, the write pointer and the gain registers; the delay line keeps
// no reset, since output is gated to zero until it has refilled.
module state_space_euler_step_with_delay #(
	parameter int DELAY_DEPTH = 16384
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [sseds_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sseds_pkg::CFG_DATA_W-1:0]       cfg_data,
	sseds_in_if.sink                               feed,
	sseds_out_if.source                            result
);

	sseds_pkg::cfg_t  cfg_q;
	sseds_pkg::ctrl_t ctrl;

	logic                                  out_valid_q;
	logic signed [sseds_pkg::SAMPLE_W-1:0] out_sample_q;
	logic                                  out_sat_q;
	logic                                  out_free;
	logic signed [sseds_pkg::SAMPLE_W-1:0] y;
	logic signed [sseds_pkg::SAMPLE_W-1:0] delayed;
	logic                                  sat;

	// Register bank. Every index of the three-bit field names a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sseds_pkg::REG_STATE_GAIN_11: cfg_q.g11 <= cfg_data[31:0];
				sseds_pkg::REG_STATE_GAIN_12: cfg_q.g12 <= cfg_data[31:0];
				sseds_pkg::REG_STATE_GAIN_21: cfg_q.g21 <= cfg_data[31:0];
				sseds_pkg::REG_STATE_GAIN_22: cfg_q.g22 <= cfg_data[31:0];
				sseds_pkg::REG_INPUT_GAIN_1:  cfg_q.h1  <= cfg_data[31:0];
				sseds_pkg::REG_INPUT_GAIN_2:  cfg_q.h2  <= cfg_data[31:0];
				sseds_pkg::REG_OUTPUT_WEIGHTS: begin
					cfg_q.c1 <= cfg_data[31:0];
					cfg_q.c2 <= cfg_data[63:32];
				end
				sseds_pkg::REG_DELAY_STEPS: cfg_q.delay <= cfg_data[sseds_pkg::DELAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The sequencer may publish when the output register is empty or is
	// being emptied in this same cycle.
	assign out_free = !out_valid_q || result.ready;

	sseds_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (feed.valid),
		.out_free (out_free),
		.in_ready (feed.ready),
		.ctrl     (ctrl)
	);

	sseds_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg       (cfg_q),
		.sample_in (feed.sample_in),
		.restart   (feed.restart),
		.y         (y),
		.sat       (sat)
	);

	sseds_dly #(
		.DEPTH (DELAY_DEPTH)
	) u_dly (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.delay_steps (cfg_q.delay),
		.restart     (feed.restart),
		.y           (y),
		.delayed     (delayed)
	);

	// Output register: loaded at the publish step, held while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fire && ctrl.w.act == sseds_pkg::ACT_PUBLISH) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire && ctrl.w.act == sseds_pkg::ACT_PUBLISH) begin
			out_sample_q <= delayed;
			out_sat_q    <= sat;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = out_sample_q;
	assign result.saturated  = out_sat_q;

endmodule
